/* design/hrp_pkg.sv */
`default_nettype none
package hrp_pkg;

  localparam int LENGTH_BITS_DEF       = 32;
  localparam int HEADER_COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF       = 4;

  localparam int NAME_LEN = 14;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [9:0] CODE_OK       = 10'd200;
  localparam logic [9:0] CODE_REDIRECT = 10'd302;

  localparam logic [7:0] NAME_UPPER [NAME_LEN] = '{
    8'h43, 8'h4F, 8'h4E, 8'h54, 8'h45, 8'h4E, 8'h54,
    8'h2D, 8'h4C, 8'h45, 8'h4E, 8'h47, 8'h54, 8'h48
  };
  localparam logic [7:0] NAME_MIXED [NAME_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
    8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
  };

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_HEADER,
    PH_BODY,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_STATUS,
    ERR_REDIRECT,
    ERR_STATUS,
    ERR_NO_LENGTH,
    ERR_ZERO_LENGTH
  } err_t;

  // classified input word
  typedef struct packed {
    logic [7:0]          data;
    logic                sor;
    logic                is_space;
    logic                is_cr;
    logic                is_lf;
    logic                is_colon;
    logic                is_digit;
    logic [3:0]          digit;
    logic [NAME_LEN-1:0] hit_upper;
    logic [NAME_LEN-1:0] hit_mixed;
  } hrp_class_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        body_last;
    logic        header_done;
    logic [2:0]  fault;
    logic [9:0]  http_status;
    logic [31:0] content_length;
    logic [15:0] header_length;
  } hrp_result_t;

endpackage
`default_nettype wire

/* design/hrp_fifo.sv */
`default_nettype none
module hrp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* design/hrp_front.sv */
`default_nettype none
module hrp_front (
  input  wire logic [7:0]         data_byte,
  input  wire logic               start_of_response,
  output hrp_pkg::hrp_class_t     cls
);

  always_comb begin
    cls           = '0;
    cls.data      = data_byte;
    cls.sor       = start_of_response;
    cls.is_space  = (data_byte == hrp_pkg::CH_SPACE);
    cls.is_cr     = (data_byte == hrp_pkg::CH_CR);
    cls.is_lf     = (data_byte == hrp_pkg::CH_LF);
    cls.is_colon  = (data_byte == hrp_pkg::CH_COLON);
    cls.is_digit  = (data_byte >= hrp_pkg::CH_ZERO) && (data_byte <= hrp_pkg::CH_NINE);
    cls.digit     = data_byte[3:0];
    // per-position header name compare, the back end picks by line position
    for (int i = 0; i < hrp_pkg::NAME_LEN; i++) begin
      cls.hit_upper[i] = (data_byte == hrp_pkg::NAME_UPPER[i]);
      cls.hit_mixed[i] = (data_byte == hrp_pkg::NAME_MIXED[i]);
    end
  end

endmodule
`default_nettype wire

/* design/hrp_back.sv */
`default_nettype none
module hrp_back #(
  parameter int LENGTH_BITS       = hrp_pkg::LENGTH_BITS_DEF,
  parameter int HEADER_COUNT_BITS = hrp_pkg::HEADER_COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire hrp_pkg::hrp_class_t  cls,
  input  wire logic                 res_full,
  output logic                      fire,
  output hrp_pkg::hrp_result_t      res
);

  localparam int LB  = LENGTH_BITS;
  localparam int HCB = HEADER_COUNT_BITS;

  hrp_pkg::phase_t phase_r, phase_nxt, cur_phase;
  hrp_pkg::err_t   err_r, err_nxt, cur_err;
  logic            space_r, space_nxt, cur_space;
  logic [2:0]      digits_r, digits_nxt, cur_digits;
  logic [9:0]      code_r, code_nxt, cur_code;
  logic            stopped_r, stopped_nxt, cur_stopped;
  logic [1:0]      crlf_r, crlf_nxt, cur_crlf;
  logic [3:0]      line_pos_r, line_pos_nxt, cur_line_pos;
  logic [1:0]      match_r, match_nxt, cur_match;
  logic [1:0]      vphase_r, vphase_nxt, cur_vphase;
  logic [LB-1:0]   length_r, length_nxt, cur_length;
  logic            seen_r, seen_nxt, cur_seen;
  logic [HCB-1:0]  hdr_r, hdr_nxt, cur_hdr;
  logic [LB-1:0]   body_r, body_nxt, cur_body;

  logic in_status, in_header, in_body;
  logic st_space, st_first_fail, st_second, st_len_fail, st_ok, st_redir, st_eol;
  logic hd_end, hd_line, hd_done;
  logic body_take, body_last;
  logic [1:0]      match_cmp;
  logic [12:0]     code_mul;
  logic [LB+3:0]   len_mul;
  logic            len_sat;
  logic [63:0]     len_ext;
  logic [31:0]     hdr_ext;

  assign fire = item_valid && !res_full;

  // a new response clears everything before its first word is taken
  assign cur_phase    = cls.sor ? hrp_pkg::PH_STATUS : phase_r;
  assign cur_err      = cls.sor ? hrp_pkg::ERR_NONE  : err_r;
  assign cur_space    = cls.sor ? 1'b0  : space_r;
  assign cur_digits   = cls.sor ? '0    : digits_r;
  assign cur_code     = cls.sor ? '0    : code_r;
  assign cur_stopped  = cls.sor ? 1'b0  : stopped_r;
  assign cur_crlf     = cls.sor ? '0    : crlf_r;
  assign cur_line_pos = cls.sor ? '0    : line_pos_r;
  assign cur_match    = cls.sor ? 2'b11 : match_r;
  assign cur_vphase   = cls.sor ? '0    : vphase_r;
  assign cur_length   = cls.sor ? '0    : length_r;
  assign cur_seen     = cls.sor ? 1'b0  : seen_r;
  assign cur_hdr      = cls.sor ? '0    : hdr_r;
  assign cur_body     = cls.sor ? '0    : body_r;

  assign in_status = (cur_phase == hrp_pkg::PH_STATUS);
  assign in_header = (cur_phase == hrp_pkg::PH_HEADER);
  assign in_body   = (cur_phase == hrp_pkg::PH_BODY);

  assign st_space      = in_status && cls.is_space;
  assign st_first_fail = st_space && !cur_space && (cur_hdr == '0);
  assign st_second     = st_space && cur_space;
  assign st_len_fail   = st_second && (cur_digits != 3'd3);
  assign st_ok         = st_second && (cur_digits == 3'd3) && !cur_stopped &&
                         (cur_code == hrp_pkg::CODE_OK);
  assign st_redir      = st_second && (cur_digits == 3'd3) && !cur_stopped &&
                         (cur_code == hrp_pkg::CODE_REDIRECT);
  assign st_eol        = in_status && (cls.is_cr || cls.is_lf);

  assign hd_end  = in_header && cls.is_lf && (cur_crlf == 2'd3);
  assign hd_line = in_header && cls.is_lf && (cur_crlf == 2'd1);
  assign hd_done = hd_end && cur_seen && (cur_length != '0);

  assign body_take = in_body && (cur_body < cur_length);
  assign body_last = body_take && ((cur_body + LB'(1)) == cur_length);

  assign match_cmp = cur_match & {cls.hit_mixed[cur_line_pos], cls.hit_upper[cur_line_pos]};
  assign code_mul  = {cur_code, 3'b000} + {2'b00, cur_code, 1'b0} + {9'd0, cls.digit};
  assign len_mul   = {1'b0, cur_length, 3'b000} + {3'b000, cur_length, 1'b0} +
                     {{LB{1'b0}}, cls.digit};
  assign len_sat   = |len_mul[LB+3:LB];

  // phase and error
  always_comb begin
    phase_nxt = cur_phase;
    err_nxt   = cur_err;
    priority if (st_first_fail || st_len_fail || st_eol) begin
      phase_nxt = hrp_pkg::PH_HALT;
      err_nxt   = hrp_pkg::ERR_BAD_STATUS;
    end else if (st_ok) begin
      phase_nxt = hrp_pkg::PH_HEADER;
    end else if (st_redir) begin
      phase_nxt = hrp_pkg::PH_HALT;
      err_nxt   = hrp_pkg::ERR_REDIRECT;
    end else if (st_second) begin
      phase_nxt = hrp_pkg::PH_HALT;
      err_nxt   = hrp_pkg::ERR_STATUS;
    end else if (hd_end && !cur_seen) begin
      phase_nxt = hrp_pkg::PH_HALT;
      err_nxt   = hrp_pkg::ERR_NO_LENGTH;
    end else if (hd_end && (cur_length == '0)) begin
      phase_nxt = hrp_pkg::PH_HALT;
      err_nxt   = hrp_pkg::ERR_ZERO_LENGTH;
    end else if (hd_end) begin
      phase_nxt = hrp_pkg::PH_BODY;
    end
  end

  // parse datapath
  always_comb begin
    space_nxt    = cur_space;
    digits_nxt   = cur_digits;
    code_nxt     = cur_code;
    stopped_nxt  = cur_stopped;
    crlf_nxt     = cur_crlf;
    line_pos_nxt = cur_line_pos;
    match_nxt    = cur_match;
    vphase_nxt   = cur_vphase;
    length_nxt   = cur_length;
    seen_nxt     = cur_seen;
    hdr_nxt      = cur_hdr;
    body_nxt     = cur_body;

    if ((in_status || in_header) && (cur_hdr != '1)) begin
      hdr_nxt = cur_hdr + HCB'(1);
    end

    if (in_status) begin
      if (cls.is_space) begin
        if (!cur_space && (cur_hdr != '0)) begin
          space_nxt = 1'b1;
        end
        if (st_ok) begin
          crlf_nxt     = '0;
          line_pos_nxt = '0;
          match_nxt    = '0;
          vphase_nxt   = '0;
        end
      end else if (!cls.is_cr && !cls.is_lf && cur_space) begin
        if ((cur_digits < 3'd3) && !cur_stopped) begin
          if (cls.is_digit) begin
            code_nxt = code_mul[9:0];
          end else begin
            stopped_nxt = 1'b1;
          end
        end
        if (cur_digits != 3'd7) begin
          digits_nxt = cur_digits + 3'd1;
        end
      end
    end

    if (hd_line) begin
      if ((cur_match != '0) && (cur_line_pos >= 4'(hrp_pkg::NAME_LEN))) begin
        seen_nxt = 1'b1;
      end
      line_pos_nxt = '0;
      match_nxt    = 2'b11;
      vphase_nxt   = '0;
      crlf_nxt     = 2'd2;
    end else if (in_header && !hd_end) begin
      if (cls.is_cr) begin
        crlf_nxt = (cur_crlf == 2'd2) ? 2'd3 : 2'd1;
      end else begin
        crlf_nxt = '0;
      end
      if (cur_line_pos < 4'(hrp_pkg::NAME_LEN)) begin
        match_nxt    = match_cmp;
        line_pos_nxt = cur_line_pos + 4'd1;
        if ((cur_line_pos == 4'(hrp_pkg::NAME_LEN - 1)) && (match_cmp != '0)) begin
          length_nxt = '0;
        end
      end else begin
        if (cur_match != '0) begin
          unique case (cur_vphase)
            2'd0: begin
              if (!cls.is_colon && !cls.is_space) begin
                if (cls.is_digit) begin
                  length_nxt = {{(LB-4){1'b0}}, cls.digit};
                  vphase_nxt = 2'd1;
                end else begin
                  vphase_nxt = 2'd2;
                end
              end
            end
            2'd1: begin
              if (!cls.is_digit) begin
                vphase_nxt = 2'd2;
              end else begin
                length_nxt = len_sat ? '1 : len_mul[LB-1:0];
              end
            end
            default: begin
            end
          endcase
        end
        if (cur_line_pos != 4'd15) begin
          line_pos_nxt = cur_line_pos + 4'd1;
        end
      end
    end

    if (body_take) begin
      body_nxt = cur_body + LB'(1);
    end
  end

  // result word
  always_comb begin
    len_ext             = 64'(length_nxt);
    hdr_ext             = 32'(hdr_nxt);
    res                 = '0;
    res.body_valid      = body_take;
    res.body_byte       = body_take ? cls.data : 8'd0;
    res.body_last       = body_last;
    res.header_done     = hd_done;
    res.fault           = err_nxt;
    res.http_status     = code_nxt;
    res.content_length  = (len_ext[63:32] != '0) ? 32'hFFFF_FFFF : len_ext[31:0];
    res.header_length   = (hdr_ext[31:16] != '0) ? 16'hFFFF : hdr_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= hrp_pkg::PH_STATUS;
      err_r      <= hrp_pkg::ERR_NONE;
      space_r    <= 1'b0;
      digits_r   <= '0;
      code_r     <= '0;
      stopped_r  <= 1'b0;
      crlf_r     <= '0;
      line_pos_r <= '0;
      match_r    <= 2'b11;
      vphase_r   <= '0;
      length_r   <= '0;
      seen_r     <= 1'b0;
      hdr_r      <= '0;
      body_r     <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      err_r      <= err_nxt;
      space_r    <= space_nxt;
      digits_r   <= digits_nxt;
      code_r     <= code_nxt;
      stopped_r  <= stopped_nxt;
      crlf_r     <= crlf_nxt;
      line_pos_r <= line_pos_nxt;
      match_r    <= match_nxt;
      vphase_r   <= vphase_nxt;
      length_r   <= length_nxt;
      seen_r     <= seen_nxt;
      hdr_r      <= hdr_nxt;
      body_r     <= body_nxt;
    end
  end

  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != hrp_pkg::ERR_NONE) == (phase_r == hrp_pkg::PH_HALT))
    else $error("error code and halt phase disagree");

  a_fail_halts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (err_nxt != hrp_pkg::ERR_NONE) |=> phase_r == hrp_pkg::PH_HALT)
    else $error("failed word did not halt the parser");

  a_done_body: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.header_done |=> (phase_r == hrp_pkg::PH_BODY) && (body_r == '0) &&
                                (length_r != '0))
    else $error("header end did not enter body with a length");

  a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hrp_pkg::PH_BODY) |-> (body_r <= length_r))
    else $error("body count ran past content length");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.body_last |-> res.body_valid && (body_nxt == length_nxt))
    else $error("last flag without completing body");

endmodule
`default_nettype wire

/* design/http_response_header_parser.sv */
// Path: an accepted byte waits in the class queue, then the back end parses it and
// pushes its result word into the result queue; a full result queue stalls it.
// Throughput: one byte per cycle unless the result queue fills; the per-byte parse
// update in the back end and the one-word-per-cycle queues set this figure.
// Reset (rst_n low, synchronous): both queues empty, parser back to the status line.
`default_nettype none
module http_response_header_parser #(
  parameter int LENGTH_BITS       = hrp_pkg::LENGTH_BITS_DEF,
  parameter int HEADER_COUNT_BITS = hrp_pkg::HEADER_COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH       = hrp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_response,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_body_valid,
  output logic      [7:0]  out_body_byte,
  output logic             out_body_last,
  output logic             out_header_done,
  output logic      [2:0]  out_fault,
  output logic      [9:0]  out_http_status,
  output logic      [31:0] out_content_length,
  output logic      [15:0] out_header_length
);

  localparam int CLS_W = $bits(hrp_pkg::hrp_class_t);
  localparam int RES_W = $bits(hrp_pkg::hrp_result_t);

  hrp_pkg::hrp_class_t  cls_in, cls_q;
  hrp_pkg::hrp_result_t res_d, res_q;
  logic [CLS_W-1:0]     cls_q_bits;
  logic [RES_W-1:0]     res_q_bits;
  logic                 mid_empty, res_full, back_fire;

  hrp_front u_front (
    .data_byte         (in_data_byte),
    .start_of_response (in_start_of_response),
    .cls               (cls_in)
  );

  hrp_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (CLS_W'(cls_in)),
    .full  (in_full),
    .pop   (back_fire),
    .rdata (cls_q_bits),
    .empty (mid_empty)
  );

  assign cls_q = hrp_pkg::hrp_class_t'(cls_q_bits);

  hrp_back #(
    .LENGTH_BITS       (LENGTH_BITS),
    .HEADER_COUNT_BITS (HEADER_COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!mid_empty),
    .cls        (cls_q),
    .res_full   (res_full),
    .fire       (back_fire),
    .res        (res_d)
  );

  hrp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_fire),
    .wdata (RES_W'(res_d)),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q_bits),
    .empty (out_empty)
  );

  assign res_q              = hrp_pkg::hrp_result_t'(res_q_bits);
  assign out_body_valid     = res_q.body_valid;
  assign out_body_byte      = res_q.body_byte;
  assign out_body_last      = res_q.body_last;
  assign out_header_done    = res_q.header_done;
  assign out_fault          = res_q.fault;
  assign out_http_status    = res_q.http_status;
  assign out_content_length = res_q.content_length;
  assign out_header_length  = res_q.header_length;

endmodule
`default_nettype wire
